/* rtl/max_heap_priority_queue_macros.svh */
// Assertion macros shared by the priority queue RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Plain property, sampled on the rising edge and disabled during reset.
`define MHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define MHPQ_ASSERT_IMP(label, ante, cons, msg) \
  `MHPQ_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MHPQ_ASSERT_NXT(label, ante, cons, msg) \
  `MHPQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* rtl/mhpq_pkg.sv */
// Shared types and constants for the max priority queue.
// No dependencies; used by mhpq_cell and max_heap_priority_queue.
package mhpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;

  // Operation codes carried in the input tuser.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
  } cell_op_t;

endpackage

/* rtl/max_heap_priority_queue.sv */
// Max priority queue built as a row of sorted key cells, largest key in cell 0.
// The result word is registered and presented in the cycle after the input is accepted.
// Throughput: one word per cycle unless stalled; a single broadcast compare across the cell
// row decides every cell's next key, so the row settles in the accepting cycle.
// Reset (rst, synchronous, active high) empties the queue and drops any pending result;
// stored keys are not cleared and are only read below the element count.
module max_heap_priority_queue #(
  parameter int  CAPACITY = mhpq_pkg::CAPACITY_DEF,
  localparam int CntW     = $clog2(CAPACITY + 1),
  localparam int OutRawW  = 2 * mhpq_pkg::KEY_W + CntW,
  localparam int OutW     = ((OutRawW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [mhpq_pkg::KEY_W-1:0] s_axis_tdata,   // value
  input  logic                       s_axis_tuser,   // mode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OutW-1:0]            m_axis_tdata,   // removed_value, count, top_value, pad
  output logic [1:0]                 m_axis_tuser    // status
);
  import mhpq_pkg::*;

  `include "max_heap_priority_queue_macros.svh"

  // Element count; the cells derive their own occupancy from it.
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;

  logic            accept;
  logic            is_full;
  logic            is_empty;
  cell_op_t        op;
  status_t         status_next;

  logic signed [KEY_W-1:0] cell_data      [CAPACITY];
  logic signed [KEY_W-1:0] cell_data_next [CAPACITY];
  logic [CAPACITY-1:0]     cell_gt;

  // Registered result word.
  status_t                 out_status;
  logic signed [KEY_W-1:0] out_removed;
  logic [CntW-1:0]         out_count;
  logic signed [KEY_W-1:0] out_top;
  logic                    out_valid;

  // A new word is taken whenever the result register is empty or being drained.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_full  = count == CntW'(CAPACITY);
  assign is_empty = count == '0;

  // Only operations that succeed move the row.
  assign op.ins = accept && (s_axis_tuser == MODE_INSERT) && !is_full;
  assign op.del = accept && (s_axis_tuser == MODE_REMOVE) && !is_empty;
  assign op.key = signed'(s_axis_tdata);

  always_comb begin
    count_next  = count;
    status_next = STATUS_OK;
    if (op.ins) begin
      count_next = count + CntW'(1);
    end else if (op.del) begin
      count_next = count - CntW'(1);
    end
    if (s_axis_tuser == MODE_INSERT && is_full) begin
      status_next = STATUS_OVERFLOW;
    end else if (s_axis_tuser == MODE_REMOVE && is_empty) begin
      status_next = STATUS_UNDERFLOW;
    end
  end

  // The row of cells. Cell 0 sees a virtual left neighbour that always ranks ahead,
  // so a key larger than everything lands there; the last cell pulls in zero on removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_gt;
    logic signed [KEY_W-1:0] left_data;
    logic signed [KEY_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_gt   = 1'b1;
      assign left_data = '0;
    end else begin : g_inner_left
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
    end

    mhpq_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count),
      .left_gt    (left_gt),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .data_next  (cell_data_next[i]),
      .gt         (cell_gt[i])
    );
  end

  // Count and result register. The removed key is cell 0 before the shift, the new
  // top is cell 0 after it, and both read as zero where the model gives zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      out_status  <= status_next;
      out_removed <= op.del ? cell_data[0] : '0;
      out_count   <= count_next;
      out_top     <= (count_next == '0) ? '0 : cell_data_next[0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = OutW'({out_top, out_count, out_removed});

  `MHPQ_ASSERT(a_count_bound, count <= CntW'(CAPACITY), "element count beyond capacity")
  `MHPQ_ASSERT_IMP(a_row_sorted, count >= CntW'(2), cell_data[0] >= cell_data[1], "row unsorted")
  `MHPQ_ASSERT_NXT(a_insert_grows, op.ins, count == $past(count) + CntW'(1), "insert lost")
  `MHPQ_ASSERT_NXT(a_remove_shrinks, op.del, count == $past(count) - CntW'(1), "remove lost")

endmodule

/* rtl/mhpq_cell.sv */
// One cell of the sorted key row: holds one key and shifts with its neighbours.
// Depends on mhpq_pkg for the key width and the broadcast operation struct.
module mhpq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  mhpq_pkg::cell_op_t               op,
  input  logic [CNT_W-1:0]                 count,
  input  logic                             left_gt,
  input  logic signed [mhpq_pkg::KEY_W-1:0] left_data,
  input  logic signed [mhpq_pkg::KEY_W-1:0] right_data,
  output logic signed [mhpq_pkg::KEY_W-1:0] data,
  output logic signed [mhpq_pkg::KEY_W-1:0] data_next,
  output logic                             gt
);
  import mhpq_pkg::*;

  logic occupied;

  assign occupied = CNT_W'(IDX) < count;
  // The held key stays ahead of the new key when it is at least as large.
  assign gt = occupied && (data >= op.key);

  always_comb begin
    data_next = data;
    if (op.del) begin
      data_next = right_data;
    end else if (op.ins && !gt) begin
      data_next = left_gt ? op.key : left_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the max priority queue: streams insert and remove words
// into the block and checks every result word against a heap kept alongside.
// Depends on mhpq_pkg and max_heap_priority_queue only.
module testbench;
  import mhpq_pkg::*;

  localparam int DEPTH      = CAPACITY_DEF;
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int RES_W      = ((2 * KEY_W + COUNT_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1000;

  // One operation waiting to be offered to the block.
  typedef struct {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
  } heap_cmd_t;

  // One result word as predicted or as seen on the output.
  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] removed;
    logic [COUNT_W-1:0]      count;
    logic signed [KEY_W-1:0] top;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [KEY_W-1:0]   s_axis_tdata  = '0;   // value
  logic               s_axis_tuser  = MODE_INSERT;   // mode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [RES_W-1:0]   m_axis_tdata;   // removed_value, count, top_value, pad
  logic [1:0]         m_axis_tuser;   // status

  max_heap_priority_queue dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Operations still to be offered, and results the block still owes us.
  heap_cmd_t    pending_ops[$];
  heap_result_t owed_results[$];

  // Shadow of the heap contents. Only entries below heap_len are ever read.
  logic signed [KEY_W-1:0] heap_keys [DEPTH];
  int heap_len = 0;

  int words_in     = 0;
  int total_words  = 0;
  int hold_at      = 0;
  int mismatches   = 0;
  int n_insert     = 0;
  int n_remove     = 0;
  int n_overflow   = 0;
  int n_underflow  = 0;
  int peak_count   = 0;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  heap_cmd_t    next_cmd;
  heap_result_t predicted;
  heap_result_t seen;
  heap_result_t wanted;

  // Apply one operation to the shadow heap and work out the word it produces.
  // Keys only move past strictly smaller keys; on the way down the left child
  // wins when both children are equal and larger.
  task automatic apply_heap_op(input logic mode, input logic signed [KEY_W-1:0] key,
                               output heap_result_t res);
    int pos;
    int parent;
    int best;
    int left;
    int right;
    logic signed [KEY_W-1:0] tmp;
    res.status  = STATUS_OK;
    res.removed = '0;
    if (mode == MODE_INSERT) begin
      if (heap_len >= DEPTH) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        pos = heap_len;
        heap_keys[pos] = key;
        heap_len++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(heap_keys[parent] < heap_keys[pos])) break;
          tmp = heap_keys[parent];
          heap_keys[parent] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (heap_len == 0) begin
        res.status = STATUS_UNDERFLOW;
      end else begin
        res.removed = heap_keys[0];
        heap_keys[0] = heap_keys[heap_len - 1];
        heap_len--;
        pos = 0;
        while (pos < heap_len) begin
          best  = pos;
          left  = 2 * pos + 1;
          right = 2 * pos + 2;
          if (left < heap_len && heap_keys[left] > heap_keys[best]) best = left;
          if (right < heap_len && heap_keys[right] > heap_keys[best]) best = right;
          if (best == pos) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.count = heap_len[COUNT_W-1:0];
    res.top   = (heap_len > 0) ? heap_keys[0] : '0;
  endtask

  task automatic queue_op(input logic mode, input logic signed [KEY_W-1:0] key);
    heap_cmd_t c;
    c.mode = mode;
    c.key  = key;
    pending_ops.push_back(c);
  endtask

  // Keys are drawn from a mix of full-range values, a narrow band near zero so that
  // ties are common, and the two extremes of the signed range.
  function automatic logic signed [KEY_W-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return $signed($urandom_range(0, 8)) - 4;
    if (pick == 8) return 32'sh7FFF_FFFF;
    return 32'sh8000_0000;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s expected %0d, got %0d", mismatches, field, want, got);
  endtask

  // Idling changes with progress: first a slow sender against a slower receiver,
  // then the reverse, then both sides at full rate.
  always_comb begin
    if (words_in < total_words / 3) begin
      src_idle_pct  = 36;
      sink_idle_pct = 73;
    end else if (words_in < (2 * total_words) / 3) begin
      src_idle_pct  = 73;
      sink_idle_pct = 36;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
  end

  // Driver: a new word is only presented once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_cmd = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_cmd.key;
        s_axis_tuser  <= next_cmd.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long hold-off on the output, late in the run when the sender never idles,
  // so that the block backs up and has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Monitor: predicts each accepted input word first, then checks any result word
  // accepted on the same edge against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_heap_op(s_axis_tuser, s_axis_tdata, predicted);
        owed_results.push_back(predicted);
        words_in++;
        if (s_axis_tuser == MODE_INSERT) n_insert++;
        else n_remove++;
        if (predicted.status == STATUS_OVERFLOW) n_overflow++;
        if (predicted.status == STATUS_UNDERFLOW) n_underflow++;
        if (heap_len > peak_count) peak_count = heap_len;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status  = status_t'(m_axis_tuser);
        seen.removed = m_axis_tdata[KEY_W-1:0];
        seen.count   = m_axis_tdata[KEY_W +: COUNT_W];
        seen.top     = m_axis_tdata[KEY_W + COUNT_W +: KEY_W];
        if (owed_results.size() == 0) begin
          note_mismatch("unexpected result word, status", -1, seen.status);
        end else begin
          wanted = owed_results.pop_front();
          if (seen.status !== wanted.status)
            note_mismatch("status", wanted.status, seen.status);
          if (seen.removed !== wanted.removed)
            note_mismatch("removed_value", wanted.removed, seen.removed);
          if (seen.count !== wanted.count)
            note_mismatch("count", wanted.count, seen.count);
          if (seen.top !== wanted.top)
            note_mismatch("top_value", wanted.top, seen.top);
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int len;
    int ins_pct;
    int k;

    // Directed opening: remove from an empty queue, both key extremes, -1 and 0,
    // equal keys, a full drain followed by two more empty removes, and ascending
    // keys that must climb all the way to the root.
    queue_op(MODE_REMOVE, 32'sh0000_0000);
    queue_op(MODE_INSERT, 32'sh0000_0000);
    queue_op(MODE_INSERT, 32'sh7FFF_FFFF);
    queue_op(MODE_INSERT, 32'sh8000_0000);
    queue_op(MODE_INSERT, -32'sd1);
    queue_op(MODE_INSERT, 32'sd5);
    queue_op(MODE_INSERT, 32'sd5);
    queue_op(MODE_INSERT, 32'sh7FFF_FFFF);
    for (k = 0; k < 7; k++) queue_op(MODE_REMOVE, $urandom);
    queue_op(MODE_REMOVE, 32'sh7FFF_FFFF);
    queue_op(MODE_REMOVE, 32'sh8000_0000);
    queue_op(MODE_INSERT, 32'sd10);
    queue_op(MODE_INSERT, 32'sd20);
    queue_op(MODE_INSERT, 32'sd30);
    queue_op(MODE_INSERT, 32'sd40);
    queue_op(MODE_REMOVE, -32'sd1);

    // Random part in stretches that mostly fill, mostly drain or stay balanced, so
    // the queue is driven into both the full and the empty state many times over.
    seg = 0;
    while (pending_ops.size() < 22 + RANDOM_ITEMS) begin
      case (seg % 3)
        0:       ins_pct = 90;
        1:       ins_pct = 10;
        default: ins_pct = 50;
      endcase
      len = $urandom_range(80, 150);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < ins_pct) queue_op(MODE_INSERT, random_key());
        else queue_op(MODE_REMOVE, $urandom);
      end
      seg++;
    end
    total_words = pending_ops.size();
    hold_at     = (5 * total_words) / 6;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
      @(posedge clk);
    // The block registers each answer in the cycle after acceptance; further edges catch strays.
    repeat (8) @(posedge clk);
    if (owed_results.size() != 0)
      note_mismatch("result words never delivered", 0, owed_results.size());

    $display("testbench: %0d words in: %0d inserts (%0d refused as full), %0d removes (%0d on empty)",
             words_in, n_insert, n_overflow, n_remove, n_underflow);
    $display("testbench: queue reached %0d of %0d entries; %0d mismatches",
             peak_count, DEPTH, mismatches);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

/* max_heap_priority_queue.f */
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/max_heap_priority_queue.sv
tb/testbench.sv
